@@ hw/rtl/gba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gba_pkg: shared types and GF(2^128) helpers for the GHASH accumulator
// Holds the bit-order conversion and the digit step of the serial multiplier.
// ----------------------------------------------------------------------------
package gba_pkg;

    localparam int unsigned BlockBits  = 128;
    localparam int unsigned HalfBits   = 64;
    localparam int unsigned DigitBits  = 16;
    localparam int unsigned DigitSteps = BlockBits / DigitBits;
    localparam int unsigned StepBits   = $clog2(DigitSteps);
    localparam int unsigned BlockBytes = BlockBits / 8;

    // Configuration register indexes
    localparam logic [2:0] RegKeyHigh   = 3'd0;
    localparam logic [2:0] RegKeyLow    = 3'd1;
    localparam logic [2:0] RegStartHigh = 3'd2;
    localparam logic [2:0] RegStartLow  = 3'd3;

    typedef logic [BlockBits-1:0] t_block;
    typedef logic [DigitBits-1:0] t_digit;

    // Swap between the GCM wire order (x^0 at the top bit) and plain
    // polynomial order (x^i at bit i).
    function automatic t_block bitrev(input t_block v);
        t_block r;
        for (int i = 0; i < BlockBits; i++) begin
            r[i] = v[BlockBits-1-i];
        end
        return r;
    endfunction

    // One Horner step: a * x^16 + d * h, reduced by x^128+x^7+x^2+x+1.
    function automatic t_block gf_step(input t_block a, input t_block h, input t_digit d);
        logic [BlockBits+DigitBits-1:0] acc;
        t_digit                         t;
        t_block                         r;
        acc = {a, {DigitBits{1'b0}}};
        for (int j = 0; j < DigitBits; j++) begin
            if (d[j]) begin
                acc = acc ^ ({{DigitBits{1'b0}}, h} << j);
            end
        end
        t = acc[BlockBits+DigitBits-1:BlockBits];
        r = acc[BlockBits-1:0]
            ^ {{(BlockBits-DigitBits){1'b0}}, t}
            ^ {{(BlockBits-DigitBits-1){1'b0}}, t, 1'b0}
            ^ {{(BlockBits-DigitBits-2){1'b0}}, t, 2'b0}
            ^ {{(BlockBits-DigitBits-7){1'b0}}, t, 7'b0};
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gba_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gba_mul: digit-serial GF(2^128) multiplier
// Consumes the multiplicand 16 bits a cycle, highest powers first.
// ----------------------------------------------------------------------------
module gba_mul
    import gba_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_block i_x,      // multiplicand, polynomial order
    input  wire t_block i_h,      // key, polynomial order
    output logic        o_last,   // final step happens this cycle
    output t_block      o_z       // product, valid while o_last is high
);

    t_block                r_x;
    t_block                r_h;
    t_block                r_a;
    logic [StepBits-1:0]   r_cnt;
    logic                  r_run;
    t_block                n_a;

    assign n_a    = gf_step(r_a, r_h, r_x[BlockBits-1 -: DigitBits]);
    assign o_z    = n_a;
    assign o_last = r_run && (r_cnt == StepBits'(DigitSteps - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_last) begin
                r_run <= 1'b0;
            end
        end
    end

    // Datapath: load on start, then fold in one digit and advance per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_h <= i_h;
            r_a <= '0;
        end else if (r_run) begin
            r_x <= r_x << DigitBits;
            r_a <= n_a;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ghash_block_accumulator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ghash_block_accumulator_top: GCM GHASH block accumulator
// Absorbs 16-byte blocks into a 128-bit accumulator and multiplies by H.
// ----------------------------------------------------------------------------
// Usage:
//   Load H and the start value through the cfg channel (index 0..3: key high,
//   key low, start high, start low) while the block is idle; other indexes
//   are dropped. Each request on the s channel carries one data block and a
//   count of leading valid bytes; bytes past the count are zeroed. The tuser
//   bit marks the first block of a message and reloads the accumulator from
//   the start registers. Each request yields one m request with the updated
//   accumulator.
//   Flow: the accepting edge loads the serial multiplier, which then folds
//   in one 16-bit digit per cycle until all eight digits are in; its final
//   step fills the output register (or the hold state, if that is still
//   full). No new block is taken until the block is idle again. A request
//   with zero valid bytes skips the multiply and passes the (possibly
//   reloaded) accumulator through the hold state to the output register.
//   The result sits in an output register; when the receiver stalls, the
//   next block is still accepted and computed, then held until the output
//   register frees up.
//   Reset clears the keys, start value, accumulator and all handshakes.
// ----------------------------------------------------------------------------
module ghash_block_accumulator_top
    import gba_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    // input blocks
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [135:0] i_s_tdata,  // [63:0] block_high, [127:64] block_low,
                                          // [132:128] valid_bytes, [135:133] zero
    input  wire logic         i_s_tuser,  // [0] first_block
    // results
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata   // [63:0] hash_high, [127:64] hash_low
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_HOLD
    } t_state;

    t_state       r_state;
    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic [63:0]  r_start_high;
    logic [63:0]  r_start_low;
    t_block       r_acc;
    t_block       r_out;
    logic         r_out_valid;

    logic         s_accept;
    logic [4:0]   valid_bytes;
    logic         no_bytes;
    t_block       block_raw;
    t_block       block_mask;
    t_block       acc_src;
    t_block       mul_x;
    logic         mul_start;
    logic         mul_last;
    t_block       mul_z;
    logic         out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out[HalfBits-1:0], r_out[BlockBits-1:HalfBits]};

    // Unpack the block: byte 0 at the top bit, as on the GCM wire
    assign block_raw   = {i_s_tdata[63:0], i_s_tdata[127:64]};
    assign valid_bytes = i_s_tdata[132:128];
    assign no_bytes    = (valid_bytes == 5'd0);

    // Keep the leading bytes; a count above sixteen keeps them all
    always_comb begin
        for (int b = 0; b < BlockBytes; b++) begin
            block_mask[BlockBits-1-8*b -: 8] = (5'(b) < valid_bytes) ? 8'hFF : 8'h00;
        end
    end

    assign acc_src   = i_s_tuser ? {r_start_high, r_start_low} : r_acc;
    assign mul_x     = bitrev(acc_src ^ (block_raw & block_mask));
    assign mul_start = s_accept && !no_bytes;

    gba_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_h     (bitrev({r_key_high, r_key_low})),
        .o_last  (mul_last),
        .o_z     (mul_z)
    );

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_start_high <= '0;
            r_start_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegKeyHigh:   r_key_high   <= i_cfg_data;
                RegKeyLow:    r_key_low    <= i_cfg_data;
                RegStartHigh: r_start_high <= i_cfg_data;
                RegStartLow:  r_start_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control: state, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_acc <= acc_src;
                        // empty block: skip the multiply, just report
                        r_state <= no_bytes ? ST_HOLD : ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_last) begin
                        r_acc <= bitrev(mul_z);
                        if (out_free) begin
                            r_out       <= bitrev(mul_z);
                            r_out_valid <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_out       <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sim/tb_ghash_block_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// tb_ghash_block_accumulator_top: self-checking bench for the GHASH accumulator
// Drives data blocks and register writes through the stream and write ports,
// keeps its own GF(2^128) hash predictor and compares every result against it
// while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_ghash_block_accumulator_top
    import gba_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [63:0] hash_high;
        logic [63:0] hash_low;
    } t_hash_pair;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data  = '0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata   = '0;
    logic         i_s_tuser   = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [127:0] o_m_tdata;

    ghash_block_accumulator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Predictor state, {high half, low half} in GCM wire order
    logic [127:0] hash_key   = '0;
    logic [127:0] start_val  = '0;
    logic [127:0] hash_acc   = '0;

    t_hash_pair   hash_expect_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_burst    = 0;
    int recv_burst    = 0;
    int cycle_count   = 0;
    int blocks_sent   = 0;
    int hashes_seen   = 0;
    int messages_sent = 0;
    int reg_writes    = 0;
    int hash_errors   = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    // Multiply by H one coefficient at a time, x^0 at the top bit.
    function automatic logic [127:0] gf128_times_key(input logic [127:0] x);
        logic [127:0] z;
        logic [127:0] v;
        logic         carry;
        z = '0;
        v = hash_key;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i]) z ^= v;
            carry = v[0];
            v     = v >> 1;
            if (carry) v[127:120] ^= 8'hE1;
        end
        return z;
    endfunction

    function automatic t_hash_pair absorb_block(input logic [63:0] bh, input logic [63:0] bl,
                                                input logic [4:0] nbytes, input logic first);
        int           n;
        logic [127:0] keep;
        t_hash_pair   res;
        n = (nbytes > 5'd16) ? 16 : int'(nbytes);
        if (first) hash_acc = start_val;
        if (n != 0) begin
            // keep the leading n bytes, zero the rest
            keep     = ~({128{1'b1}} >> (8 * n));
            hash_acc = gf128_times_key(hash_acc ^ ({bh, bl} & keep));
        end
        res.hash_high = hash_acc[127:64];
        res.hash_low  = hash_acc[63:0];
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready with bursts of steady acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (recv_burst > 0) begin
            recv_burst <= recv_burst - 1;
            i_m_tready <= 1'b1;
        end else if ($urandom_range(999) < 5) begin
            recv_burst <= $urandom_range(60, 20);
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_hash_pair want;
        t_hash_pair got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.hash_high = o_m_tdata[63:0];
            got.hash_low  = o_m_tdata[127:64];
            hashes_seen++;
            if (hash_expect_q.size() == 0) begin
                if (hash_errors < MAX_REPORTS)
                    $display("unexpected result: hash_high=%h hash_low=%h",
                             got.hash_high, got.hash_low);
                hash_errors++;
            end else begin
                want = hash_expect_q.pop_front();
                if (got.hash_high !== want.hash_high || got.hash_low !== want.hash_low) begin
                    if (hash_errors < MAX_REPORTS)
                        $display("hash mismatch #%0d: high exp %h got %h, low exp %h got %h",
                                 hashes_seen, want.hash_high, got.hash_high,
                                 want.hash_low, got.hash_low);
                    hash_errors++;
                end
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[ghash_block_accumulator_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one block request; record its prediction once it is taken.
    task automatic send_block(input logic [63:0] bh, input logic [63:0] bl,
                              input logic [4:0] nbytes, input logic first);
        int gap;
        gap = 0;
        if (send_burst > 0) begin
            send_burst--;
        end else if ($urandom_range(999) < 5) begin
            send_burst = $urandom_range(60, 20);
        end else begin
            // idle each cycle with the sender's idle odds
            while ($urandom_range(99) < send_idle_pct) gap++;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, nbytes, bl, bh};
        i_s_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        hash_expect_q.push_back(absorb_block(bh, bl, nbytes, first));
        blocks_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            RegKeyHigh:   hash_key[127:64]  = val;
            RegKeyLow:    hash_key[63:0]    = val;
            RegStartHigh: start_val[127:64] = val;
            RegStartLow:  start_val[63:0]   = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Load H and the start value; throw in a write to an unmapped index.
    task automatic program_regs(input logic [127:0] key, input logic [127:0] start);
        write_reg(3'($urandom_range(7, 4)), rand_word());
        write_reg(RegKeyHigh,   key[127:64]);
        write_reg(RegKeyLow,    key[63:0]);
        write_reg(RegStartHigh, start[127:64]);
        write_reg(RegStartLow,  start[63:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and let every outstanding hash come back.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hash_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers and accumulator start out at zero.
    task automatic test_after_reset();
        send_block('1, '1, 5'd0, 1'b0);
        send_block('1, '1, 5'd16, 1'b1);
        wait_idle();
    endtask

    // Identity key (x^0) makes the hash the plain XOR, exposing the start value.
    task automatic test_register_map();
        logic [127:0] start;
        start = {rand_word(), rand_word()};
        write_reg(3'd4, '1);
        write_reg(3'd5, '1);
        write_reg(3'd6, '1);
        write_reg(3'd7, '1);
        program_regs({1'b1, 127'b0}, start);
        send_block('0, '0, 5'd0, 1'b1);
        send_block(rand_word(), rand_word(), 5'd16, 1'b0);
        send_block('1, '1, 5'd0, 1'b0);
        wait_idle();
    endtask

    // A spread of byte counts from one to sixteen, plus counts past sixteen.
    task automatic test_byte_counts();
        logic [4:0] counts[8] = '{5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31};
        program_regs({rand_word(), rand_word()}, {rand_word(), rand_word()});
        foreach (counts[k]) send_block('1, '1, counts[k], 1'b1);
        send_block('1, '1, 5'd0, 1'b0);
        wait_idle();
    endtask

    // All-ones key and start, then a key of x^127 so every step reduces.
    task automatic test_key_extremes();
        program_regs('1, '1);
        send_block('1, '1, 5'd16, 1'b1);
        send_block('0, '0, 5'd16, 1'b0);
        wait_idle();
        program_regs(128'h1, '0);
        send_block('0, 64'h1, 5'd16, 1'b1);
        send_block('1, '1, 5'd16, 1'b0);
        wait_idle();
    endtask

    // Mostly whole messages (first block, full middle blocks, tail of 1 to 16 bytes);
    // the rest is stray items with any count or flag.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int rounds, input int items_per_round);
        int         len;
        int         sent;
        logic [4:0] tail;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int r = 0; r < rounds; r++) begin
            case (r)
                0:       program_regs('1, '0);
                1:       program_regs({rand_word(), rand_word()}, '1);
                default: program_regs({rand_word(), rand_word()}, {rand_word(), rand_word()});
            endcase
            sent = 0;
            while (sent < items_per_round) begin
                if ($urandom_range(99) < 85) begin
                    len  = $urandom_range(8, 1);
                    tail = $urandom_range(1) ? 5'd16 : 5'($urandom_range(16, 1));
                    for (int k = 0; k < len; k++)
                        send_block(rand_word(), rand_word(),
                                   (k == len - 1) ? tail : 5'd16, k == 0);
                    sent += len;
                    messages_sent++;
                end else begin
                    send_block(rand_word(), rand_word(), 5'($urandom_range(31)),
                               1'($urandom_range(1)));
                    sent++;
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 61;
        test_after_reset();
        test_register_map();
        test_byte_counts();
        test_key_extremes();

        test_random_traffic(22, 61, 4, 163);
        test_random_traffic(61, 22, 4, 163);
        test_random_traffic(0, 0, 4, 163);

        $display("covered %0d blocks (%0d whole messages) and %0d register writes",
                 blocks_sent, messages_sent, reg_writes);
        $display("checked %0d hashes, %0d bad, %0d never returned",
                 hashes_seen, hash_errors, hash_expect_q.size());
        if (hash_errors == 0 && hash_expect_q.size() == 0) begin
            $display("[ghash_block_accumulator_top] OK");
        end else begin
            $display("[ghash_block_accumulator_top] ERROR");
        end
        $finish;
    end

endmodule
